[sv/rbr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the reorder buffer receiver.
package rbr_pkg;

  localparam int WINDOW      = 32;
  localparam int PAYLOAD_MAX = 508;

  localparam int SEQ_W  = 31;
  localparam int LEN_W  = 9;
  localparam int REF_W  = 16;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int NXT_W  = SEQ_W + 1;
  localparam int DIFF_W = SEQ_W + 2;

  typedef enum logic [1:0] {
    ST_IN_ORDER  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_BUFFERED  = 2'd2,
    ST_DROPPED   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [REF_W-1:0] handle;
  } slot_t;

endpackage

[sv/rbr_ifs.sv]
`timescale 1ns / 1ps
// Packet and result channels of the reorder buffer receiver.
interface rbr_pkt_if import rbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_num;
  logic [LEN_W-1:0] pkt_len;
  logic [REF_W-1:0] payload_ref;

  modport source (output valid, output seq_num, output pkt_len, output payload_ref,
                  input ready);
  modport sink (input valid, input seq_num, input pkt_len, input payload_ref,
                output ready);
endinterface

interface rbr_res_if import rbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SEQ_W-1:0] out_seq;
  logic [LEN_W-1:0] out_len;
  logic [REF_W-1:0] out_ref;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, output kind, output out_seq, output out_len,
                  output out_ref, output status, output last, input ready);
  modport sink (input valid, input kind, input out_seq, input out_len,
                input out_ref, input status, input last, output ready);
endinterface

[sv/reorder_buffer_receiver_top.sv]
`timescale 1ns / 1ps
// Reorder buffer receiver of a selective-repeat link: top level.
//
// pkt_i carries one arriving data packet per transaction (sequence number,
// length, payload handle). res_o carries the results: first an
// acknowledgement with a status (in order, duplicate, buffered, dropped),
// then for an in-order packet its delivery and the deliveries of every
// consecutively numbered packet held in the window store. last marks the
// final result of each packet.
// A packet is accepted into the packet registers, and its acknowledgement is then
// placed in the output register; an in-order packet then adds its deliveries.
// The drain runs at one delivery a cycle while the receiver is ready, set by the
// single read port of the slot memory.
// Lengths and handles sit in that memory; valid bits and the next expected
// number sit in flip-flops.
// Reset clears the next expected number and all valid bits at once; no
// clearing pass is needed. A stalled receiver holds the output register and
// stalls any packet in progress; pkt_i is ready only when no packet is in progress.
module reorder_buffer_receiver_top import rbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbr_pkt_if.sink    pkt_i,
  rbr_res_if.source  res_o
);

  typedef enum logic [1:0] {S_IDLE, S_ACK, S_FIRST, S_DRAIN} state_e;

  state_e             state_q, state_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [REF_W-1:0]   ref_q, ref_d;
  status_e            cls_q, cls_d;
  logic [IDX_W-1:0]   slot_idx_q, slot_idx_d;
  logic [NXT_W-1:0]   nxt_q, nxt_d;
  logic [IDX_W-1:0]   nxt_idx_q, nxt_idx_d;
  logic [WINDOW-1:0]  valid_q, valid_d;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [SEQ_W-1:0]   out_seq_q, out_seq_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic [REF_W-1:0]   out_ref_q, out_ref_d;
  status_e            out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  slot_t              mem [WINDOW];
  slot_t              rdata_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  logic               accept, out_free;
  logic [DIFF_W-1:0]  diff;
  logic [IDX_W:0]     slot_sum;
  logic [LEN_W-1:0]   len_clamped;
  logic [NXT_W-1:0]   nxt_inc;
  logic [IDX_W-1:0]   idx_inc;
  logic               run_on;

  assign accept   = pkt_i.valid && pkt_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign pkt_i.ready = (state_q == S_IDLE);

  assign diff = {2'b00, pkt_i.seq_num} - {1'b0, nxt_q};
  assign slot_sum = {1'b0, nxt_idx_q} + {1'b0, diff[IDX_W-1:0]};
  assign len_clamped = (int'(pkt_i.pkt_len) > PAYLOAD_MAX) ? LEN_W'(PAYLOAD_MAX)
                                                             : pkt_i.pkt_len;

  // next number and its slot after one delivery
  assign nxt_inc = nxt_q + NXT_W'(1);
  assign idx_inc = (nxt_idx_q == IDX_W'(WINDOW - 1)) ? '0 : nxt_idx_q + IDX_W'(1);
  assign run_on  = !nxt_inc[NXT_W-1] && valid_q[idx_inc];

  always_comb begin
    state_d      = state_q;
    seq_d        = seq_q;
    len_d        = len_q;
    ref_d        = ref_q;
    cls_d        = cls_q;
    slot_idx_d   = slot_idx_q;
    nxt_d        = nxt_q;
    nxt_idx_d    = nxt_idx_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_kind_d   = out_kind_q;
    out_seq_d    = out_seq_q;
    out_len_d    = out_len_q;
    out_ref_d    = out_ref_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = idx_inc;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          seq_d = pkt_i.seq_num;
          len_d = len_clamped;
          ref_d = pkt_i.payload_ref;
          if (diff[DIFF_W-1]) begin
            cls_d = ST_DUPLICATE;
          end else if (diff == '0) begin
            cls_d = ST_IN_ORDER;
          end else if (diff < DIFF_W'(WINDOW)) begin
            cls_d = ST_BUFFERED;
          end else begin
            cls_d = ST_DROPPED;
          end
          slot_idx_d = (slot_sum >= (IDX_W+1)'(WINDOW))
                       ? IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : slot_sum[IDX_W-1:0];
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_ACK;
          out_seq_d    = seq_q;
          out_len_d    = '0;
          out_ref_d    = '0;
          out_status_d = cls_q;
          out_last_d   = (cls_q != ST_IN_ORDER);
          // keep the first copy of a repeated packet
          if (cls_q == ST_BUFFERED && !valid_q[slot_idx_q]) begin
            mem_we = 1'b1;
            valid_d[slot_idx_q] = 1'b1;
          end
          state_d = (cls_q == ST_IN_ORDER) ? S_FIRST : S_IDLE;
        end
      end
      S_FIRST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_DELIVER;
          out_seq_d    = seq_q;
          out_len_d    = len_q;
          out_ref_d    = ref_q;
          out_status_d = ST_IN_ORDER;
          out_last_d   = !run_on;
          nxt_d        = nxt_inc;
          nxt_idx_d    = idx_inc;
          mem_re       = run_on;
          state_d      = run_on ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_DELIVER;
          out_seq_d    = nxt_q[SEQ_W-1:0];
          out_len_d    = rdata_q.len;
          out_ref_d    = rdata_q.handle;
          out_status_d = ST_IN_ORDER;
          out_last_d   = !run_on;
          valid_d[nxt_idx_q] = 1'b0;
          nxt_d        = nxt_inc;
          nxt_idx_d    = idx_inc;
          mem_re       = run_on;
          state_d      = run_on ? S_DRAIN : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nxt_q       <= '0;
      nxt_idx_q   <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_q       <= nxt_d;
      nxt_idx_q   <= nxt_idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    len_q        <= len_d;
    ref_q        <= ref_d;
    cls_q        <= cls_d;
    slot_idx_q   <= slot_idx_d;
    out_kind_q   <= out_kind_d;
    out_seq_q    <= out_seq_d;
    out_len_q    <= out_len_d;
    out_ref_q    <= out_ref_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_idx_q] <= '{len: len_q, handle: ref_q};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.kind    = out_kind_q;
  assign res_o.out_seq = out_seq_q;
  assign res_o.out_len = out_len_q;
  assign res_o.out_ref = out_ref_q;
  assign res_o.status  = out_status_q;
  assign res_o.last    = out_last_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the reorder buffer receiver: random packet streams against a predictor.
module tb;
  import rbr_pkg::*;

  localparam int     QUIET_LIMIT = 2000;
  localparam int     TAIL_CYCLES = 40;
  localparam int     RANDOM_ITEMS = 250;
  localparam longint SEQ_MAX = (64'd1 << SEQ_W) - 1;

  typedef struct {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [REF_W-1:0] handle;
    bit               hold_idle;
  } packet_t;

  typedef struct {
    kind_e            kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [REF_W-1:0] handle;
    status_e          status;
    logic             last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rbr_pkt_if pkt_if ();
  rbr_res_if res_if ();

  reorder_buffer_receiver_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .res_o  (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  packet_t packets_to_send [$];
  result_t results_due [$];
  int      packets_total;
  int      packets_accepted;
  int      mismatch_count;
  int      quiet_cycles;
  logic    pkt_moved;
  int unsigned send_gap, send_calm, stall_left, stall_calm;

  // Predictor state
  logic [NXT_W-1:0] want_seq;
  logic             held_valid [WINDOW];
  logic [LEN_W-1:0] held_len [WINDOW];
  logic [REF_W-1:0] held_ref [WINDOW];

  // Stimulus planning state, tracks where the stream stands
  longint plan_next;
  bit     plan_held [WINDOW];
  bit     pause_pending;

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_W'(PAYLOAD_MAX);
      2: return LEN_W'($urandom_range(PAYLOAD_MAX + 1, 2**LEN_W - 1));
      default: return LEN_W'($urandom_range(0, 2**LEN_W - 1));
    endcase
  endfunction

  function automatic logic [REF_W-1:0] rand_ref();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return REF_W'($urandom_range(0, 2**REF_W - 1));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] l);
    return (l > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : l;
  endfunction

  function automatic result_t make_result(kind_e k, logic [SEQ_W-1:0] s,
                                          logic [LEN_W-1:0] l, logic [REF_W-1:0] h,
                                          status_e st);
    result_t r;
    r.kind   = k;
    r.seq    = s;
    r.len    = l;
    r.handle = h;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic queue_packet(input longint s, input logic [LEN_W-1:0] l,
                              input logic [REF_W-1:0] h);
    packet_t p;
    p.seq       = s[SEQ_W-1:0];
    p.len       = l;
    p.handle    = h;
    p.hold_idle = pause_pending;
    pause_pending = 1'b0;
    packets_to_send.push_back(p);
    if (s == plan_next) begin
      plan_next++;
      while (plan_next <= SEQ_MAX && plan_held[plan_next % WINDOW]) begin
        plan_held[plan_next % WINDOW] = 1'b0;
        plan_next++;
      end
    end else if (s > plan_next && s < plan_next + WINDOW) begin
      plan_held[s % WINDOW] = 1'b1;
    end
  endtask

  task automatic predict_results(input packet_t p);
    logic [DIFF_W-1:0] s;
    int                idx;
    result_t           r;
    s = DIFF_W'(p.seq);
    if (s < DIFF_W'(want_seq)) begin
      results_due.push_back(make_result(KIND_ACK, p.seq, '0, '0, ST_DUPLICATE));
    end else if (s == DIFF_W'(want_seq)) begin
      results_due.push_back(make_result(KIND_ACK, p.seq, '0, '0, ST_IN_ORDER));
      results_due.push_back(make_result(KIND_DELIVER, p.seq, clamp_len(p.len), p.handle,
                                        ST_IN_ORDER));
      want_seq = NXT_W'(s) + 1'b1;
      idx = int'(want_seq % WINDOW);
      // drain the run of held packets that follows without a gap
      while (want_seq <= SEQ_MAX && held_valid[idx]) begin
        results_due.push_back(make_result(KIND_DELIVER, want_seq[SEQ_W-1:0], held_len[idx],
                                          held_ref[idx], ST_IN_ORDER));
        held_valid[idx] = 1'b0;
        want_seq++;
        idx = int'(want_seq % WINDOW);
      end
    end else if (s < DIFF_W'(want_seq) + DIFF_W'(WINDOW)) begin
      idx = int'(p.seq % WINDOW);
      results_due.push_back(make_result(KIND_ACK, p.seq, '0, '0, ST_BUFFERED));
      // keep the first copy of a repeated packet
      if (!held_valid[idx]) begin
        held_valid[idx] = 1'b1;
        held_len[idx]   = clamp_len(p.len);
        held_ref[idx]   = p.handle;
      end
    end else begin
      results_due.push_back(make_result(KIND_ACK, p.seq, '0, '0, ST_DROPPED));
    end
    r = results_due.pop_back();
    r.last = 1'b1;
    results_due.push_back(r);
  endtask

  task automatic report(input string msg);
    if (mismatch_count < 100) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_result(input result_t want, input result_t got);
    if (got.kind !== want.kind)
      report($sformatf("seq %0d kind got %0d want %0d", want.seq, got.kind, want.kind));
    if (got.seq !== want.seq)
      report($sformatf("seq got %0d want %0d", got.seq, want.seq));
    if (got.len !== want.len)
      report($sformatf("seq %0d len got %0d want %0d", want.seq, got.len, want.len));
    if (got.handle !== want.handle)
      report($sformatf("seq %0d handle got %h want %h", want.seq, got.handle, want.handle));
    if (got.status !== want.status)
      report($sformatf("seq %0d status got %0d want %0d", want.seq, got.status, want.status));
    if (got.last !== want.last)
      report($sformatf("seq %0d last got %0d want %0d", want.seq, got.last, want.last));
  endtask

  // Packet driver
  always @(negedge clk_i) begin : drive_packets
    packet_t p;
    if (rst_ni) begin
      if (!pkt_if.valid || pkt_moved) begin
        if (send_gap > 0) begin
          send_gap--;
          pkt_if.valid <= 1'b0;
        end else if (packets_to_send.size() != 0 &&
                     !(packets_to_send[0].hold_idle && results_due.size() != 0)) begin
          p = packets_to_send.pop_front();
          pkt_if.seq_num     <= p.seq;
          pkt_if.pkt_len     <= p.len;
          pkt_if.payload_ref <= p.handle;
          pkt_if.valid       <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          pkt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_gap(stall_calm);
      end
    end
  end

  // Monitor: check results, predict from accepted packets, watch for a hang
  always @(posedge clk_i) begin : watch_channels
    result_t got;
    packet_t p;
    if (!rst_ni) begin
      pkt_moved <= 1'b0;
    end else begin
      pkt_moved <= pkt_if.valid && pkt_if.ready;
      if (res_if.valid && res_if.ready) begin
        got.kind   = kind_e'(res_if.kind);
        got.seq    = res_if.out_seq;
        got.len    = res_if.out_len;
        got.handle = res_if.out_ref;
        got.status = status_e'(res_if.status);
        got.last   = res_if.last;
        if (results_due.size() == 0)
          report($sformatf("unexpected result for seq %0d", got.seq));
        else
          check_result(results_due.pop_front(), got);
      end
      if (pkt_if.valid && pkt_if.ready) begin
        p.seq       = pkt_if.seq_num;
        p.len       = pkt_if.pkt_len;
        p.handle    = pkt_if.payload_ref;
        p.hold_idle = 1'b0;
        predict_results(p);
        packets_accepted++;
      end
      if ((res_if.valid && res_if.ready) || (pkt_if.valid && pkt_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    longint order [$];
    longint base, s, tmp;
    int     k, j, random_count, next_pause_at;
    bit     broken, full_first;

    pkt_if.valid       = 1'b0;
    pkt_if.seq_num     = '0;
    pkt_if.pkt_len     = '0;
    pkt_if.payload_ref = '0;
    res_if.ready       = 1'b0;
    want_seq = '0;
    plan_next = 0;
    pause_pending = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      held_valid[i] = 1'b0;
      plan_held[i]  = 1'b0;
    end

    // Directed: every status, window edges, oversized lengths, repeats, short drain
    queue_packet(0, '0, '0);
    queue_packet(0, LEN_W'(PAYLOAD_MAX), '1);
    queue_packet(2, '1, '1);
    queue_packet(2, 9'd7, 16'h0001);
    queue_packet(3, LEN_W'(PAYLOAD_MAX), 16'h1234);
    queue_packet(WINDOW, 9'd509, 16'hAAAA);
    queue_packet(WINDOW + 1, 9'd1, 16'h5555);
    queue_packet(SEQ_MAX, '0, '0);
    queue_packet(longint'(1) << (SEQ_W - 1), 9'd256, 16'h8000);
    pause_pending = 1'b1;
    queue_packet(1, 9'd510, 16'h5555);
    queue_packet(3, 9'd3, 16'h0003);
    queue_packet(4, 9'd511, 16'h7FFF);
    queue_packet(plan_next + WINDOW - 1, 9'd100, 16'hBEEF);
    queue_packet(plan_next + WINDOW, 9'd100, 16'hDEAD);

    // Random: mostly windows of shuffled packets closed by the expected one
    random_count = 0;
    next_pause_at = 0;
    full_first = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      if (random_count >= next_pause_at) begin
        pause_pending = 1'b1;
        next_pause_at += 80;
      end
      if ($urandom_range(0, 9) < 7) begin
        k = (full_first || $urandom_range(0, 9) == 0) ? WINDOW - 1 : $urandom_range(1, 12);
        broken = (k != WINDOW - 1) && ($urandom_range(0, 4) == 0);
        full_first = 1'b0;
        base = plan_next;
        order.delete();
        for (int i = 1; i <= k; i++) order.push_back(base + i);
        for (int i = order.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < order.size(); i++) begin
          // leave holes in a broken window
          if (broken && $urandom_range(0, 3) == 0) continue;
          queue_packet(order[i], rand_len(), rand_ref());
          random_count++;
          if ($urandom_range(0, 9) == 0) begin
            queue_packet(order[$urandom_range(0, i)], rand_len(), rand_ref());
            random_count++;
          end
        end
        if (!(broken && $urandom_range(0, 1) == 0)) begin
          queue_packet(base, rand_len(), rand_ref());
          random_count++;
        end
      end else begin
        case ($urandom_range(0, 4))
          0: s = (plan_next == 0) ? 0 : longint'($urandom_range(0, int'(plan_next - 1)));
          1: s = plan_next + WINDOW + $urandom_range(0, 3);
          2: s = plan_next + WINDOW - 1;
          default: begin
            s = longint'($urandom) & SEQ_MAX;
            if (s >= plan_next && s < plan_next + WINDOW) s += WINDOW;
          end
        endcase
        queue_packet(s, rand_len(), rand_ref());
        random_count++;
      end
    end
    packets_total = packets_to_send.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (packets_accepted < packets_total || results_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
